### hw/rtl/psud_pkg.sv
// psud_pkg: shared types, codes and constants of the response deframer
package psud_pkg;

  // fixed frame constants
  localparam logic [7:0] SYNC_BYTE    = 8'h55;
  localparam logic [7:0] SYNC2_BYTE   = 8'hAA;
  localparam logic [7:0] NACK_BYTE    = 8'hF5;
  localparam logic [7:0] REQ_LEN_BYTE = 8'h04;
  localparam int         REQ_COUNT    = 6;
  localparam int         STORE_DEPTH  = 58;
  localparam int         ST_AW        = $clog2(STORE_DEPTH);
  localparam int         FRAME_MIN    = 6;
  localparam int         FRAME_OVH    = 6;
  localparam int         LEN_ADD      = 2;
  localparam int         CK_TAIL      = 2;
  localparam int         ECHO_POS     = 3;
  localparam int         PAY_OFS      = 4;

  // reset values of the settings
  localparam logic [5:0] CAP_RESET    = 6'd16;
  localparam logic [7:0] LIMIT_RESET  = 8'd128;

  // settings port
  localparam int                    CFG_IDX_W    = 1;
  localparam int                    CFG_DW       = 8;
  localparam logic [CFG_IDX_W-1:0]  CFG_PAY_CAP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_SYNC_LIM = 1'b1;

  // input commands
  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_RX       = 2'd1,
    CMD_DEADLINE = 2'd2,
    CMD_BUSERR   = 2'd3
  } cmd_code_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_PAY  = 2'd1,
    KIND_STAT = 2'd2
  } kind_t;

  // status codes
  typedef enum logic [3:0] {
    STS_OK        = 4'd0,
    STS_NACK      = 4'd1,
    STS_NO_SYNC   = 4'd2,
    STS_BAD_AA    = 4'd3,
    STS_BAD_LEN   = 4'd4,
    STS_CMD_MIS   = 4'd5,
    STS_CHECKSUM  = 4'd6,
    STS_TOO_LARGE = 4'd7,
    STS_DEADLINE  = 4'd8,
    STS_BUS_ERR   = 4'd9
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    start;
    logic    count_sync;
    logic    load_len;
    logic    body_byte;
    logic    set_stat;
    status_t stat;
    logic    emit_clear;
    logic    emit_step;
    logic    out_load;
    kind_t   out_kind;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_nack;
    logic is_sync;
    logic is_sync2;
    logic hunt_exhausted;
    logic len_bad;
    logic body_final;
    logic cmd_mismatch;
    logic cksum_bad;
    logic too_large;
    logic len_zero;
    logic req_done;
    logic pay_done;
  } dp_sts_t;

endpackage

### hw/rtl/psud_in_if.sv
// psud_in_if: input word channel with valid/ready handshake
interface psud_in_if import psud_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

### hw/rtl/psud_out_if.sv
// psud_out_if: result word channel with valid/ready handshake
interface psud_out_if import psud_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [3:0] status;
  logic       last;

  modport source (output valid, out_kind, out_byte, status, last, input ready);
  modport sink   (input valid, out_kind, out_byte, status, last, output ready);
endinterface

### hw/rtl/psud_ctrl.sv
// psud_ctrl: frame phase and result sequencing state machine
module psud_ctrl import psud_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    dp_cmd,
  input  dp_sts_t    dp_sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_HUNT, S_AA, S_LEN, S_BODY, S_REQ, S_PAY, S_STAT
  } state_t;

  state_t    state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      slot_free;
  logic      in_fire;
  logic      fail;
  status_t   fail_code;
  cmd_code_t cmd_c;

  assign cmd_c     = cmd_code_t'(in_cmd);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r inside {S_IDLE, S_HUNT, S_AA, S_LEN, S_BODY});
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dp_cmd        = '0;
    fail          = 1'b0;
    fail_code     = STS_OK;
    unique case (state_r)
      S_IDLE, S_HUNT, S_AA, S_LEN, S_BODY: begin
        if (in_fire) begin
          if (cmd_c == CMD_START) begin
            dp_cmd.start      = 1'b1;
            dp_cmd.emit_clear = 1'b1;
            state_nxt         = S_REQ;
          end else if (state_r == S_IDLE) begin
            state_nxt = S_IDLE;
          end else if (cmd_c == CMD_DEADLINE) begin
            fail      = 1'b1;
            fail_code = STS_DEADLINE;
          end else if (cmd_c == CMD_BUSERR) begin
            fail      = 1'b1;
            fail_code = STS_BUS_ERR;
          end else begin
            case (state_r)
              S_HUNT: begin
                if (dp_sts.hunt_exhausted) begin
                  fail      = 1'b1;
                  fail_code = STS_NO_SYNC;
                end else begin
                  dp_cmd.count_sync = 1'b1;
                  if (dp_sts.is_nack) begin
                    fail      = 1'b1;
                    fail_code = STS_NACK;
                  end else if (dp_sts.is_sync) begin
                    state_nxt = S_AA;
                  end
                end
              end
              S_AA: begin
                if (!dp_sts.is_sync2) begin
                  fail      = 1'b1;
                  fail_code = STS_BAD_AA;
                end else begin
                  state_nxt = S_LEN;
                end
              end
              S_LEN: begin
                if (dp_sts.len_bad) begin
                  fail      = 1'b1;
                  fail_code = STS_BAD_LEN;
                end else begin
                  dp_cmd.load_len = 1'b1;
                  state_nxt       = S_BODY;
                end
              end
              default: begin
                // body bytes, then the three final checks
                if (!dp_sts.body_final) begin
                  dp_cmd.body_byte = 1'b1;
                end else if (dp_sts.cmd_mismatch) begin
                  fail      = 1'b1;
                  fail_code = STS_CMD_MIS;
                end else if (dp_sts.cksum_bad) begin
                  fail      = 1'b1;
                  fail_code = STS_CHECKSUM;
                end else if (dp_sts.too_large) begin
                  fail      = 1'b1;
                  fail_code = STS_TOO_LARGE;
                end else begin
                  dp_cmd.set_stat   = 1'b1;
                  dp_cmd.stat       = STS_OK;
                  dp_cmd.emit_clear = 1'b1;
                  state_nxt         = dp_sts.len_zero ? S_STAT : S_PAY;
                end
              end
            endcase
          end
        end
      end
      S_REQ: begin
        if (slot_free) begin
          dp_cmd.out_load  = 1'b1;
          dp_cmd.out_kind  = KIND_REQ;
          dp_cmd.emit_step = 1'b1;
          if (dp_sts.req_done) begin
            state_nxt = S_HUNT;
          end
        end
      end
      S_PAY: begin
        if (slot_free) begin
          dp_cmd.out_load  = 1'b1;
          dp_cmd.out_kind  = KIND_PAY;
          dp_cmd.emit_step = 1'b1;
          if (dp_sts.pay_done) begin
            state_nxt = S_STAT;
          end
        end
      end
      S_STAT: begin
        if (slot_free) begin
          dp_cmd.out_load = 1'b1;
          dp_cmd.out_kind = KIND_STAT;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // any failure leaves one status word
    if (fail) begin
      dp_cmd.set_stat = 1'b1;
      dp_cmd.stat     = fail_code;
      state_nxt       = S_STAT;
    end
    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/psud_dp.sv
// psud_dp: frame registers, running sum, payload store and result register
module psud_dp import psud_pkg::*; #(
  parameter int FRAME_MAX = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  input  logic [7:0]           in_byte,
  input  dp_cmd_t              dp_cmd,
  output dp_sts_t              dp_sts,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_byte,
  output logic [3:0]           out_status,
  output logic                 out_last
);

  localparam int FLEN_W = $clog2(FRAME_MAX + 1);
  localparam int CMP_W  = (FLEN_W > 7) ? FLEN_W : 7;

  logic [5:0]       cap_r;
  logic [7:0]       limit_r;
  logic [7:0]       exp_cmd_r;
  logic [7:0]       sync_cnt_r;
  logic [FLEN_W-1:0] flen_r;
  logic [FLEN_W-1:0] bidx_r;
  logic [15:0]      sum_r;
  logic [7:0]       echo_r;
  logic [7:0]       cklo_r;
  status_t          stat_r;
  logic [ST_AW-1:0] idx_r, idx_nxt;
  logic [ST_AW-1:0] rd_addr;
  logic [7:0]       rd_data_r;
  logic [7:0]       store_mem [STORE_DEPTH];
  logic [1:0]       out_kind_r;
  logic [7:0]       out_byte_r;
  logic [3:0]       out_status_r;
  logic             out_last_r;

  logic [8:0]       n9;
  logic             is_data;
  logic             is_cklo;
  logic [CMP_W-1:0] widx;
  logic             wr_en;
  logic [CMP_W-1:0] len_wide;
  logic [5:0]       cap_eff;
  logic [7:0]       req_byte;
  logic [7:0]       ld_byte;

  // byte compares and frame position
  assign n9       = {1'b0, in_byte} + 9'(LEN_ADD);
  assign is_data  = bidx_r < (flen_r - FLEN_W'(CK_TAIL));
  assign is_cklo  = bidx_r == (flen_r - FLEN_W'(CK_TAIL));
  assign widx     = CMP_W'(bidx_r) - CMP_W'(PAY_OFS);
  assign wr_en    = dp_cmd.body_byte && is_data && (bidx_r != FLEN_W'(ECHO_POS)) &&
                    (widx < CMP_W'(STORE_DEPTH));
  assign len_wide = CMP_W'(flen_r) - CMP_W'(FRAME_OVH);
  assign cap_eff  = (cap_r > 6'(STORE_DEPTH)) ? 6'(STORE_DEPTH) : cap_r;

  always_comb begin
    dp_sts.is_nack        = in_byte == NACK_BYTE;
    dp_sts.is_sync        = in_byte == SYNC_BYTE;
    dp_sts.is_sync2       = in_byte == SYNC2_BYTE;
    dp_sts.hunt_exhausted = sync_cnt_r >= limit_r;
    dp_sts.len_bad        = (n9 < 9'(FRAME_MIN)) || (n9 > 9'(FRAME_MAX));
    dp_sts.body_final     = !is_data && !is_cklo;
    dp_sts.cmd_mismatch   = echo_r != exp_cmd_r;
    dp_sts.cksum_bad      = (cklo_r != sum_r[7:0]) || (in_byte != sum_r[15:8]);
    dp_sts.too_large      = len_wide > CMP_W'(cap_eff);
    dp_sts.len_zero       = len_wide == '0;
    dp_sts.req_done       = idx_r == ST_AW'(REQ_COUNT - 1);
    dp_sts.pay_done       = CMP_W'(idx_r + ST_AW'(1)) == len_wide;
  end

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAY_CAP:  cap_r   <= cfg_wdata[5:0];
        CFG_SYNC_LIM: limit_r <= cfg_wdata;
      endcase
    end
  end

  // query and frame registers
  always_ff @(posedge clk) begin
    if (dp_cmd.start) begin
      exp_cmd_r  <= in_byte;
      sync_cnt_r <= '0;
    end else if (dp_cmd.count_sync) begin
      sync_cnt_r <= sync_cnt_r + 8'd1;
    end
    if (dp_cmd.load_len) begin
      flen_r <= FLEN_W'(n9);
      sum_r  <= {8'd0, in_byte};
      bidx_r <= FLEN_W'(ECHO_POS);
    end else if (dp_cmd.body_byte) begin
      if (is_data) begin
        if (bidx_r == FLEN_W'(ECHO_POS)) begin
          echo_r <= in_byte;
        end
        sum_r <= sum_r + {8'd0, in_byte};
      end else begin
        cklo_r <= in_byte;
      end
      bidx_r <= bidx_r + FLEN_W'(1);
    end
    if (dp_cmd.set_stat) begin
      stat_r <= dp_cmd.stat;
    end
  end

  // emit counter; read address runs one step ahead of the data register
  always_comb begin
    idx_nxt = idx_r;
    if (dp_cmd.emit_clear) begin
      idx_nxt = '0;
    end else if (dp_cmd.emit_step) begin
      idx_nxt = idx_r + ST_AW'(1);
    end
  end
  assign rd_addr = (idx_nxt < ST_AW'(STORE_DEPTH)) ? idx_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[widx[ST_AW-1:0]] <= in_byte;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // request byte select
  always_comb begin
    case (idx_r)
      ST_AW'(0): req_byte = SYNC_BYTE;
      ST_AW'(1): req_byte = SYNC2_BYTE;
      ST_AW'(2): req_byte = REQ_LEN_BYTE;
      ST_AW'(3): req_byte = exp_cmd_r;
      ST_AW'(4): req_byte = exp_cmd_r + REQ_LEN_BYTE;
      default:   req_byte = 8'd0;
    endcase
  end

  always_comb begin
    case (dp_cmd.out_kind)
      KIND_REQ: ld_byte = req_byte;
      KIND_PAY: ld_byte = rd_data_r;
      default:  ld_byte = 8'd0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (dp_cmd.out_load) begin
      out_kind_r   <= dp_cmd.out_kind;
      out_byte_r   <= ld_byte;
      out_status_r <= (dp_cmd.out_kind == KIND_STAT) ? stat_r : STS_OK;
      out_last_r   <= (dp_cmd.out_kind == KIND_STAT) ||
                      ((dp_cmd.out_kind == KIND_REQ) && dp_sts.req_done);
    end
  end

  assign out_kind   = out_kind_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

### hw/rtl/psu_response_deframer.sv
// psu_response_deframer: top level of the supply query framer and response parser
//
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        cmd[1:0], data_byte[7:0]
//  out_chan  out  valid/ready        out_kind[1:0], out_byte[7:0], status[3:0], last
//  cfg_*     in   write enable only  cfg_index[0], cfg_wdata[7:0]
//
// A word that leaves no result is taken when offered; the next one is taken the cycle after.
// A word with results blocks the input until its last result is loaded into the single
// output register: one result per cycle while the output is not stalled (6 for a request,
// payload length + 1 for a good frame, 1 for a failure), set by the output register.
// Reset (synchronous, rst_n low) returns to idle and restores capacity 16 and limit 128.
// A stalled output holds its word; input is refused meanwhile only while results remain.
module psu_response_deframer import psud_pkg::*; #(
  parameter int FRAME_MAX = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  psud_in_if.sink              in_chan,
  psud_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // controller
  psud_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_cmd    (in_chan.cmd),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  // datapath
  psud_dp #(
    .FRAME_MAX (FRAME_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_chan.data_byte),
    .dp_cmd     (dp_cmd),
    .dp_sts     (dp_sts),
    .out_kind   (out_chan.out_kind),
    .out_byte   (out_chan.out_byte),
    .out_status (out_chan.status),
    .out_last   (out_chan.last)
  );

  // a status word closes its sequence and carries no byte
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.out_kind == KIND_STAT) |->
      (out_chan.last && out_chan.out_byte == 8'd0))
    else $error("status word without last or with a byte");

  // while more results of a word remain, no new word is taken
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.last) |-> !in_chan.ready)
    else $error("input taken while results still pending");

  // byte words carry a zero status
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.out_kind != KIND_STAT) |-> (out_chan.status == 4'd0))
    else $error("byte word with non-zero status");

endmodule
